FILE: rtl/core/ifrd_pkg.sv
// Shared types, constants and codes of the info frame receiver and destuffer.
package ifrd_pkg;

  // Line framing bytes.
  localparam logic [7:0] FlagByte = 8'h5C;
  localparam logic [7:0] EscByte  = 8'h5D;
  localparam logic [7:0] EscFlag  = 8'h7C;
  localparam logic [7:0] EscEsc   = 8'h7D;

  // Control bytes.
  localparam logic [7:0] CtrlI0   = 8'h00;
  localparam logic [7:0] CtrlI1   = 8'h02;
  localparam logic [7:0] CtrlDisc = 8'h11;
  localparam logic [7:0] CtrlRr0  = 8'h01;
  localparam logic [7:0] CtrlRr1  = 8'h21;
  localparam logic [7:0] CtrlRej0 = 8'h05;
  localparam logic [7:0] CtrlRej1 = 8'h25;

  // Payload limit and counter widths.
  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned LenW       = 11;

  // Command queue between front and back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);

  // A response frame is five bytes after the status.
  localparam int unsigned RespBeats = 5;
  localparam int unsigned BeatW     = $clog2(RespBeats + 1);

  // Output widths.
  localparam int unsigned KindW     = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned OutDataW  = 24;

  // Receive phases.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_FLAG = 3'd1,
    PH_ADDR = 3'd2,
    PH_CTRL = 3'd3,
    PH_DATA = 3'd4,
    PH_ESC  = 3'd5,
    PH_DISC = 3'd6
  } phase_e;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_STATUS   = 2'd1,
    KIND_RESPONSE = 2'd2
  } kind_e;

  // Frame status codes.
  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED   = 3'd0,
    ST_BCC2_ERROR = 3'd1,
    ST_BAD_ESCAPE = 3'd2,
    ST_DISCONNECT = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_e;

  // Queued command kinds.
  typedef enum logic [1:0] {
    CMD_PAYLOAD     = 2'd0,
    CMD_STATUS      = 2'd1,
    CMD_STATUS_RESP = 2'd2
  } cmd_e;

  // One queued command: data holds the payload byte or the response control.
  typedef struct packed {
    cmd_e            op;
    logic [7:0]      data;
    status_e         status;
    logic [LenW-1:0] len;
    logic            seq;
  } cmd_t;

endpackage

FILE: rtl/core/ifrd_front.sv
// Front part: frame parser, destuffer and BCC2 checker that issues commands.
module ifrd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        link_address_i,
  output logic              cmd_valid_o,
  output ifrd_pkg::cmd_t    cmd_o
);

  ifrd_pkg::phase_e            phase_q, phase_d;
  logic                        exp_seq_q, exp_seq_d;
  logic                        cur_seq_q, cur_seq_d;
  logic [7:0]                  hdr_ctrl_q, hdr_ctrl_d;
  logic [7:0]                  held_q, held_d;
  logic                        held_vld_q, held_vld_d;
  logic [7:0]                  xor_q, xor_d;
  logic [ifrd_pkg::CntW-1:0]   cnt_q, cnt_d;

  logic                        is_ictrl;
  logic                        overflow;
  logic                        good;
  logic [ifrd_pkg::LenW-1:0]   len_now;

  // Shared conditions.
  assign is_ictrl = ((rx_byte_i == ifrd_pkg::CtrlI0) && !exp_seq_q) ||
                    ((rx_byte_i == ifrd_pkg::CtrlI1) && exp_seq_q);
  assign overflow = held_vld_q && (cnt_q >= ifrd_pkg::CntW'(ifrd_pkg::MaxPayload));
  assign good     = held_vld_q && (held_q == xor_q);
  assign len_now  = ifrd_pkg::LenW'(cnt_q);

  // Next receive phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      ifrd_pkg::PH_HUNT: begin
        if (rx_byte_i == ifrd_pkg::FlagByte) phase_d = ifrd_pkg::PH_FLAG;
      end
      ifrd_pkg::PH_FLAG: begin
        if (rx_byte_i == link_address_i) phase_d = ifrd_pkg::PH_ADDR;
        else if (rx_byte_i != ifrd_pkg::FlagByte) phase_d = ifrd_pkg::PH_HUNT;
      end
      ifrd_pkg::PH_ADDR: begin
        priority if (is_ictrl) phase_d = ifrd_pkg::PH_CTRL;
        else if (rx_byte_i == ifrd_pkg::FlagByte) phase_d = ifrd_pkg::PH_FLAG;
        else if (rx_byte_i == ifrd_pkg::CtrlDisc) phase_d = ifrd_pkg::PH_DISC;
        else phase_d = ifrd_pkg::PH_HUNT;
      end
      ifrd_pkg::PH_CTRL: begin
        priority if (rx_byte_i == (link_address_i ^ hdr_ctrl_q)) phase_d = ifrd_pkg::PH_DATA;
        else if (rx_byte_i == ifrd_pkg::FlagByte) phase_d = ifrd_pkg::PH_FLAG;
        else phase_d = ifrd_pkg::PH_HUNT;
      end
      ifrd_pkg::PH_DATA: begin
        priority if (rx_byte_i == ifrd_pkg::FlagByte) phase_d = ifrd_pkg::PH_HUNT;
        else if (rx_byte_i == ifrd_pkg::EscByte) phase_d = ifrd_pkg::PH_ESC;
        else if (overflow) phase_d = ifrd_pkg::PH_HUNT;
        else phase_d = ifrd_pkg::PH_DATA;
      end
      ifrd_pkg::PH_ESC: begin
        if ((rx_byte_i == ifrd_pkg::EscFlag || rx_byte_i == ifrd_pkg::EscEsc) && !overflow)
          phase_d = ifrd_pkg::PH_DATA;
        else
          phase_d = ifrd_pkg::PH_HUNT;
      end
      ifrd_pkg::PH_DISC: phase_d = ifrd_pkg::PH_HUNT;
      default: phase_d = ifrd_pkg::PH_HUNT;
    endcase
  end

  // Datapath updates and the command for the queue.
  always_comb begin
    logic       take;
    logic [7:0] take_byte;
    exp_seq_d   = exp_seq_q;
    cur_seq_d   = cur_seq_q;
    hdr_ctrl_d  = hdr_ctrl_q;
    held_d      = held_q;
    held_vld_d  = held_vld_q;
    xor_d       = xor_q;
    cnt_d       = cnt_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{op: ifrd_pkg::CMD_PAYLOAD, data: 8'h00,
                    status: ifrd_pkg::ST_ACCEPTED, len: '0, seq: 1'b0};
    take        = 1'b0;
    take_byte   = rx_byte_i;

    unique case (phase_q)
      ifrd_pkg::PH_ADDR: begin
        if (is_ictrl) begin
          hdr_ctrl_d = rx_byte_i;
          cur_seq_d  = exp_seq_q;
        end
      end
      ifrd_pkg::PH_CTRL: begin
        if (rx_byte_i == (link_address_i ^ hdr_ctrl_q)) begin
          held_vld_d = 1'b0;
          held_d     = 8'h00;
          xor_d      = 8'h00;
          cnt_d      = '0;
        end
      end
      ifrd_pkg::PH_DATA: begin
        priority if (rx_byte_i == ifrd_pkg::FlagByte) begin
          // Closing flag: status plus RR or REJ naming the next sequence bit.
          cmd_valid_o = 1'b1;
          cmd_o.op     = ifrd_pkg::CMD_STATUS_RESP;
          cmd_o.status = good ? ifrd_pkg::ST_ACCEPTED : ifrd_pkg::ST_BCC2_ERROR;
          cmd_o.len    = len_now;
          cmd_o.seq    = cur_seq_q;
          if (!cur_seq_q) cmd_o.data = good ? ifrd_pkg::CtrlRr1 : ifrd_pkg::CtrlRej1;
          else cmd_o.data = good ? ifrd_pkg::CtrlRr0 : ifrd_pkg::CtrlRej0;
          exp_seq_d = ~exp_seq_q;
        end else if (rx_byte_i == ifrd_pkg::EscByte) begin
          take = 1'b0;
        end else begin
          take = 1'b1;
        end
      end
      ifrd_pkg::PH_ESC: begin
        priority if (rx_byte_i == ifrd_pkg::EscFlag) begin
          take      = 1'b1;
          take_byte = ifrd_pkg::FlagByte;
        end else if (rx_byte_i == ifrd_pkg::EscEsc) begin
          take      = 1'b1;
          take_byte = ifrd_pkg::EscByte;
        end else begin
          cmd_valid_o  = 1'b1;
          cmd_o.op     = ifrd_pkg::CMD_STATUS;
          cmd_o.status = ifrd_pkg::ST_BAD_ESCAPE;
          cmd_o.len    = len_now;
          cmd_o.seq    = cur_seq_q;
        end
      end
      ifrd_pkg::PH_DISC: begin
        cmd_valid_o  = 1'b1;
        cmd_o.op     = ifrd_pkg::CMD_STATUS_RESP;
        cmd_o.status = ifrd_pkg::ST_DISCONNECT;
        cmd_o.data   = ifrd_pkg::CtrlDisc;
      end
      default: begin
        take = 1'b0;
      end
    endcase

    // Destuffed byte: release the held byte one byte late, or overflow.
    if (take) begin
      if (overflow) begin
        cmd_valid_o  = 1'b1;
        cmd_o.op     = ifrd_pkg::CMD_STATUS;
        cmd_o.status = ifrd_pkg::ST_OVERFLOW;
        cmd_o.len    = len_now;
        cmd_o.seq    = cur_seq_q;
      end else begin
        if (held_vld_q) begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = ifrd_pkg::CMD_PAYLOAD;
          cmd_o.data  = held_q;
          xor_d       = xor_q ^ held_q;
          cnt_d       = cnt_q + ifrd_pkg::CntW'(1);
        end
        held_d     = take_byte;
        held_vld_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ifrd_pkg::PH_HUNT;
      exp_seq_q  <= 1'b0;
      cur_seq_q  <= 1'b0;
      hdr_ctrl_q <= 8'h00;
      held_q     <= 8'h00;
      held_vld_q <= 1'b0;
      xor_q      <= 8'h00;
      cnt_q      <= '0;
    end else if (in_fire_i) begin
      phase_q    <= phase_d;
      exp_seq_q  <= exp_seq_d;
      cur_seq_q  <= cur_seq_d;
      hdr_ctrl_q <= hdr_ctrl_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      xor_q      <= xor_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/ifrd_cmd_fifo.sv
// Short command queue between the parsing front and the result back end.
module ifrd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ifrd_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output ifrd_pkg::cmd_t head_o
);

  ifrd_pkg::cmd_t                mem_q [ifrd_pkg::FifoDepth];
  logic [ifrd_pkg::PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ifrd_pkg::FillW-1:0]    fill_q;

  assign full_o  = (fill_q == ifrd_pkg::FillW'(ifrd_pkg::FifoDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + ifrd_pkg::PtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + ifrd_pkg::PtrW'(1);
      if (push_i && !pop_i) fill_q <= fill_q + ifrd_pkg::FillW'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - ifrd_pkg::FillW'(1);
    end
  end

endmodule

FILE: rtl/core/ifrd_back.sv
// Back end: expands queued commands into result transactions on an output register.
module ifrd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  ifrd_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic [7:0]                    link_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ifrd_pkg::KindW-1:0]    out_kind_o,
  output logic [ifrd_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_last_o
);

  logic [ifrd_pkg::BeatW-1:0]    beat_q, beat_d;
  logic                          vld_q;
  logic [ifrd_pkg::KindW-1:0]    kind_q;
  logic [ifrd_pkg::OutDataW-1:0] data_q;
  logic                          last_q;

  logic                          load;
  ifrd_pkg::kind_e               nxt_kind;
  logic [7:0]                    nxt_byte;
  ifrd_pkg::status_e             nxt_status;
  logic [ifrd_pkg::LenW-1:0]     nxt_len;
  logic                          nxt_seq;
  logic                          nxt_last;

  assign load = !cmd_empty_i && (!vld_q || out_ready_i);

  // Current beat of the command at the head of the queue.
  always_comb begin
    nxt_kind   = ifrd_pkg::KIND_PAYLOAD;
    nxt_byte   = 8'h00;
    nxt_status = ifrd_pkg::ST_ACCEPTED;
    nxt_len    = '0;
    nxt_seq    = 1'b0;
    nxt_last   = 1'b1;
    unique case (cmd_i.op)
      ifrd_pkg::CMD_PAYLOAD: begin
        nxt_byte = cmd_i.data;
      end
      ifrd_pkg::CMD_STATUS: begin
        nxt_kind   = ifrd_pkg::KIND_STATUS;
        nxt_status = cmd_i.status;
        nxt_len    = cmd_i.len;
        nxt_seq    = cmd_i.seq;
      end
      ifrd_pkg::CMD_STATUS_RESP: begin
        if (beat_q == '0) begin
          nxt_kind   = ifrd_pkg::KIND_STATUS;
          nxt_status = cmd_i.status;
          nxt_len    = cmd_i.len;
          nxt_seq    = cmd_i.seq;
          nxt_last   = 1'b0;
        end else begin
          nxt_kind = ifrd_pkg::KIND_RESPONSE;
          nxt_last = (beat_q == ifrd_pkg::BeatW'(ifrd_pkg::RespBeats));
          unique case (beat_q)
            ifrd_pkg::BeatW'(2): nxt_byte = link_address_i;
            ifrd_pkg::BeatW'(3): nxt_byte = cmd_i.data;
            ifrd_pkg::BeatW'(4): nxt_byte = link_address_i ^ cmd_i.data;
            default:             nxt_byte = ifrd_pkg::FlagByte;
          endcase
        end
      end
      default: begin
        nxt_last = 1'b1;
      end
    endcase
  end

  // Beat counter advances per loaded result and clears at the command end.
  always_comb begin
    beat_d    = beat_q;
    cmd_pop_o = 1'b0;
    if (load) begin
      if (nxt_last) begin
        beat_d    = '0;
        cmd_pop_o = 1'b1;
      end else begin
        beat_d = beat_q + ifrd_pkg::BeatW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      beat_q <= beat_d;
      if (load) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= nxt_kind;
      data_q <= {1'b0, nxt_seq, nxt_len, nxt_status, nxt_byte};
      last_q <= nxt_last;
    end
  end

  assign out_valid_o = vld_q;
  assign out_kind_o  = kind_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

FILE: rtl/core/info_frame_receiver_destuffer_core.sv
// Top level of the info frame receiver and destuffer.
//
//  Channel   Dir  Handshake                       Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready   raw line byte
//  m_axis    out  m_axis_tvalid / m_axis_tready   payload, status or response byte
//  cfg       in   cfg_valid_i / cfg_ready_o       link address
//
// A line byte is taken every cycle while the four-entry command queue has room.
// Each byte yields at most one command; a closing flag or a disconnect expands into six
// results, one per cycle unless the output stalls, from the back end output register.
// Reset puts the parser in flag hunt with sequence bit zero and address one.
// Output stalls back up into the queue and then hold off s_axis_tready.
module info_frame_receiver_destuffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data, [10:8] status,
                                      // [21:11] payload_length, [22] frame_seq, [23] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i      // [7:0] link_address
);

  logic [7:0]     link_addr_q;
  logic           in_fire;
  logic           cmd_valid;
  ifrd_pkg::cmd_t cmd;
  logic           fifo_full, fifo_empty, fifo_pop;
  ifrd_pkg::cmd_t fifo_head;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_addr_q <= 8'h01;
    end else if (cfg_valid_i) begin
      link_addr_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = !fifo_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ifrd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .rx_byte_i      (s_axis_tdata),
    .link_address_i (link_addr_q),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  ifrd_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && cmd_valid),
    .push_data_i (cmd),
    .pop_i       (fifo_pop),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .head_o      (fifo_head)
  );

  ifrd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (fifo_empty),
    .cmd_i          (fifo_head),
    .cmd_pop_o      (fifo_pop),
    .link_address_i (link_addr_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_kind_o     (m_axis_tuser),
    .out_data_o     (m_axis_tdata),
    .out_last_o     (m_axis_tlast)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the info frame receiver and destuffer core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned ItemsPerPhase = 55;

  // One result as it should leave the block.
  typedef struct packed {
    ifrd_pkg::kind_e           kind;
    logic [7:0]                data;
    ifrd_pkg::status_e         status;
    logic [ifrd_pkg::LenW-1:0] len;
    logic                      seq;
    logic                      last;
  } frame_result_t;

  // Tracks the receiver's framing state and the results each line byte should give.
  class frame_scoreboard;
    localparam int unsigned MaxReports = 40;

    logic [7:0]        link_address;
    ifrd_pkg::phase_e  phase;
    logic              exp_seq;
    logic              cur_seq;
    logic [7:0]        hdr_ctrl;
    logic [7:0]        held_byte;
    logic              held_valid;
    logic [7:0]        run_xor;
    int unsigned       byte_cnt;
    frame_result_t     awaited_results[$];
    int unsigned       errors;
    int unsigned       results_seen;

    function new();
      link_address = 8'h01;
      phase        = ifrd_pkg::PH_HUNT;
      exp_seq      = 1'b0;
      cur_seq      = 1'b0;
      hdr_ctrl     = 8'h00;
      held_byte    = 8'h00;
      held_valid   = 1'b0;
      run_xor      = 8'h00;
      byte_cnt     = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_address(input logic [7:0] value);
      link_address = value;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void emit(input ifrd_pkg::kind_e k, input logic [7:0] d,
                       input ifrd_pkg::status_e s, input int unsigned len, input logic seq);
      frame_result_t r;
      r.kind   = k;
      r.data   = d;
      r.status = s;
      r.len    = ifrd_pkg::LenW'(len);
      r.seq    = seq;
      r.last   = 1'b0;
      awaited_results.push_back(r);
    endfunction

    // Response frame: flag, address, control, header check, flag.
    function void queue_response(input logic [7:0] ctrl);
      emit(ifrd_pkg::KIND_RESPONSE, ifrd_pkg::FlagByte, ifrd_pkg::ST_ACCEPTED, 0, 1'b0);
      emit(ifrd_pkg::KIND_RESPONSE, link_address, ifrd_pkg::ST_ACCEPTED, 0, 1'b0);
      emit(ifrd_pkg::KIND_RESPONSE, ctrl, ifrd_pkg::ST_ACCEPTED, 0, 1'b0);
      emit(ifrd_pkg::KIND_RESPONSE, link_address ^ ctrl, ifrd_pkg::ST_ACCEPTED, 0, 1'b0);
      emit(ifrd_pkg::KIND_RESPONSE, ifrd_pkg::FlagByte, ifrd_pkg::ST_ACCEPTED, 0, 1'b0);
    endfunction

    // A destuffed payload byte releases the one held before it.
    function void accept_payload_byte(input logic [7:0] b);
      if (held_valid && byte_cnt >= ifrd_pkg::MaxPayload) begin
        emit(ifrd_pkg::KIND_STATUS, 8'h00, ifrd_pkg::ST_OVERFLOW, byte_cnt, cur_seq);
        phase = ifrd_pkg::PH_HUNT;
      end else begin
        if (held_valid) begin
          emit(ifrd_pkg::KIND_PAYLOAD, held_byte, ifrd_pkg::ST_ACCEPTED, 0, 1'b0);
          run_xor  = run_xor ^ held_byte;
          byte_cnt = byte_cnt + 1;
        end
        held_byte  = b;
        held_valid = 1'b1;
        phase      = ifrd_pkg::PH_DATA;
      end
    endfunction

    // Closing flag: the held byte is the block check of the payload.
    function void close_frame();
      logic       good;
      logic [7:0] ctrl;
      good = held_valid && (held_byte == run_xor);
      if (good) begin
        emit(ifrd_pkg::KIND_STATUS, 8'h00, ifrd_pkg::ST_ACCEPTED, byte_cnt, cur_seq);
      end else begin
        emit(ifrd_pkg::KIND_STATUS, 8'h00, ifrd_pkg::ST_BCC2_ERROR, byte_cnt, cur_seq);
      end
      if (!cur_seq) begin
        ctrl = good ? ifrd_pkg::CtrlRr1 : ifrd_pkg::CtrlRej1;
      end else begin
        ctrl = good ? ifrd_pkg::CtrlRr0 : ifrd_pkg::CtrlRej0;
      end
      queue_response(ctrl);
      exp_seq = ~exp_seq;
      phase   = ifrd_pkg::PH_HUNT;
    endfunction

    // Advances the framing state by one accepted line byte.
    function void take_line_byte(input logic [7:0] b);
      int unsigned   before_cnt;
      frame_result_t r;
      before_cnt = awaited_results.size();
      case (phase)
        ifrd_pkg::PH_HUNT: begin
          if (b == ifrd_pkg::FlagByte) phase = ifrd_pkg::PH_FLAG;
        end
        ifrd_pkg::PH_FLAG: begin
          if (b == link_address) phase = ifrd_pkg::PH_ADDR;
          else if (b != ifrd_pkg::FlagByte) phase = ifrd_pkg::PH_HUNT;
        end
        ifrd_pkg::PH_ADDR: begin
          if ((b == ifrd_pkg::CtrlI0 && !exp_seq) || (b == ifrd_pkg::CtrlI1 && exp_seq)) begin
            hdr_ctrl = b;
            cur_seq  = exp_seq;
            phase    = ifrd_pkg::PH_CTRL;
          end else if (b == ifrd_pkg::FlagByte) begin
            phase = ifrd_pkg::PH_FLAG;
          end else if (b == ifrd_pkg::CtrlDisc) begin
            phase = ifrd_pkg::PH_DISC;
          end else begin
            phase = ifrd_pkg::PH_HUNT;
          end
        end
        ifrd_pkg::PH_CTRL: begin
          if (b == (link_address ^ hdr_ctrl)) begin
            held_valid = 1'b0;
            held_byte  = 8'h00;
            run_xor    = 8'h00;
            byte_cnt   = 0;
            phase      = ifrd_pkg::PH_DATA;
          end else if (b == ifrd_pkg::FlagByte) begin
            phase = ifrd_pkg::PH_FLAG;
          end else begin
            phase = ifrd_pkg::PH_HUNT;
          end
        end
        ifrd_pkg::PH_DATA: begin
          if (b == ifrd_pkg::FlagByte) close_frame();
          else if (b == ifrd_pkg::EscByte) phase = ifrd_pkg::PH_ESC;
          else accept_payload_byte(b);
        end
        ifrd_pkg::PH_ESC: begin
          if (b == ifrd_pkg::EscFlag) begin
            accept_payload_byte(ifrd_pkg::FlagByte);
          end else if (b == ifrd_pkg::EscEsc) begin
            accept_payload_byte(ifrd_pkg::EscByte);
          end else begin
            emit(ifrd_pkg::KIND_STATUS, 8'h00, ifrd_pkg::ST_BAD_ESCAPE, byte_cnt, cur_seq);
            phase = ifrd_pkg::PH_HUNT;
          end
        end
        ifrd_pkg::PH_DISC: begin
          emit(ifrd_pkg::KIND_STATUS, 8'h00, ifrd_pkg::ST_DISCONNECT, 0, 1'b0);
          queue_response(ifrd_pkg::CtrlDisc);
          phase = ifrd_pkg::PH_HUNT;
        end
        default: phase = ifrd_pkg::PH_HUNT;
      endcase
      // The final result caused by this byte carries the last marker.
      if (awaited_results.size() > before_cnt) begin
        r      = awaited_results.pop_back();
        r.last = 1'b1;
        awaited_results.push_back(r);
      end
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      errors = errors + 1;
      if (errors <= MaxReports) begin
        $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, results_seen, what, got, want);
      end
    endtask

    // Compares one output transaction with the oldest awaited result.
    task match_output(input logic [1:0] kind, input logic [23:0] tdata, input logic last);
      frame_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, tdata", 32'(tdata), 32'h0);
      end else begin
        want = awaited_results.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (tdata[7:0] !== want.data) begin
          report_mismatch("data", 32'(tdata[7:0]), 32'(want.data));
        end
        if (tdata[10:8] !== want.status) begin
          report_mismatch("status", 32'(tdata[10:8]), 32'(want.status));
        end
        if (tdata[21:11] !== want.len) begin
          report_mismatch("payload_length", 32'(tdata[21:11]), 32'(want.len));
        end
        if (tdata[22] !== want.seq) begin
          report_mismatch("frame_seq", 32'(tdata[22]), 32'(want.seq));
        end
        if (tdata[23] !== 1'b0) report_mismatch("tdata padding", 32'(tdata[23]), 32'h0);
        if (last !== want.last) report_mismatch("tlast", 32'(last), 32'(want.last));
      end
      results_seen = results_seen + 1;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;

  frame_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     items_sent = 0;
  int unsigned     cycle_count = 0;
  logic [7:0]      frame_payload[$];

  info_frame_receiver_destuffer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Output side: check each transaction, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.match_output(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One line byte, after a random idle gap.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_line_byte(b);
    items_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == ifrd_pkg::FlagByte) begin
      send_byte(ifrd_pkg::EscByte);
      send_byte(ifrd_pkg::EscFlag);
    end else if (b == ifrd_pkg::EscByte) begin
      send_byte(ifrd_pkg::EscByte);
      send_byte(ifrd_pkg::EscEsc);
    end else begin
      send_byte(b);
    end
  endtask

  // Header of an I-frame with the sequence bit the receiver waits for.
  task automatic send_header();
    logic [7:0] ctrl;
    send_byte(ifrd_pkg::FlagByte);
    send_byte(sb.link_address);
    ctrl = sb.exp_seq ? ifrd_pkg::CtrlI1 : ifrd_pkg::CtrlI0;
    send_byte(ctrl);
    send_byte(sb.link_address ^ ctrl);
  endtask

  // Full I-frame carrying frame_payload, with a correct or spoiled block check.
  task automatic send_info_frame(input bit spoil);
    logic [7:0] bcc;
    bcc = 8'h00;
    send_header();
    foreach (frame_payload[i]) begin
      send_stuffed(frame_payload[i]);
      bcc = bcc ^ frame_payload[i];
    end
    if (spoil) bcc = bcc ^ 8'($urandom_range(255, 1));
    send_stuffed(bcc);
    send_byte(ifrd_pkg::FlagByte);
  endtask

  task automatic send_empty_frame();
    send_header();
    send_byte(ifrd_pkg::FlagByte);
  endtask

  task automatic send_disc();
    send_byte(ifrd_pkg::FlagByte);
    send_byte(sb.link_address);
    send_byte(ifrd_pkg::CtrlDisc);
    send_byte(8'($urandom_range(255)));
  endtask

  // Payload bytes lean toward the framing and escape codes.
  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(7))
      0: return ifrd_pkg::FlagByte;
      1: return ifrd_pkg::EscByte;
      2: return ($urandom_range(1) != 0) ? ifrd_pkg::EscFlag : ifrd_pkg::EscEsc;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Stop sending, let all awaited results come out and the block go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_address(value);
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise.
  task automatic run_random(input int unsigned target);
    int unsigned first_item;
    int unsigned pick;
    int unsigned count;
    logic [7:0]  b;
    logic [7:0]  ctrl;
    first_item = items_sent;
    while (items_sent - first_item < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        frame_payload.delete();
        count = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        repeat (count) frame_payload.push_back(pick_payload_byte());
        send_info_frame($urandom_range(99) < 15);
      end else if (pick < 62) begin
        send_empty_frame();
      end else if (pick < 70) begin
        send_disc();
      end else if (pick < 78) begin
        // Escape followed by anything but the two escape codes.
        send_header();
        repeat ($urandom_range(3)) send_stuffed(pick_payload_byte());
        send_byte(ifrd_pkg::EscByte);
        do b = 8'($urandom_range(255)); while (b == ifrd_pkg::EscFlag || b == ifrd_pkg::EscEsc);
        if ($urandom_range(3) == 0) b = ifrd_pkg::FlagByte;
        send_byte(b);
      end else if (pick < 84) begin
        // Wrong sequence bit or an unknown control byte.
        send_byte(ifrd_pkg::FlagByte);
        send_byte(sb.link_address);
        ctrl = sb.exp_seq ? ifrd_pkg::CtrlI0 : ifrd_pkg::CtrlI1;
        if ($urandom_range(1) != 0) ctrl = 8'($urandom_range(255));
        send_byte(ctrl);
      end else if (pick < 90) begin
        // Bad header check, sometimes a flag that restarts the header.
        send_byte(ifrd_pkg::FlagByte);
        send_byte(sb.link_address);
        ctrl = sb.exp_seq ? ifrd_pkg::CtrlI1 : ifrd_pkg::CtrlI0;
        send_byte(ctrl);
        b = sb.link_address ^ ctrl ^ 8'($urandom_range(255, 1));
        if ($urandom_range(2) == 0 && (sb.link_address ^ ctrl) != ifrd_pkg::FlagByte) begin
          b = ifrd_pkg::FlagByte;
        end
        send_byte(b);
      end else begin
        // Line noise does not count toward the item budget.
        count = $urandom_range(4, 1);
        repeat (count) send_byte(8'($urandom_range(255)));
        items_sent = items_sent - count;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset address: good frame with both escapes,
    // empty frame, disconnect, then an escape followed by a flag.
    frame_payload = '{8'hFF, ifrd_pkg::FlagByte, ifrd_pkg::EscByte};
    send_info_frame(1'b0);
    send_empty_frame();
    send_disc();
    send_header();
    send_byte(ifrd_pkg::EscByte);
    send_byte(ifrd_pkg::FlagByte);

    // Random phases, each with its own address and idling pattern.
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          write_address(8'h00);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_address(8'hFF);
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          // Address equal to the flag byte.
          write_address(ifrd_pkg::FlagByte);
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          write_address(8'($urandom_range(255)));
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
      endcase
      run_random(ItemsPerPhase);
    end

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
